@@ rtl/nnsa_pkg.sv @@
// Shared types and constants for the nearest-neighbor scale address generator.
package nnsa_pkg;

    // Largest image dimension handled; coordinates are clamped below it
    localparam int NNSA_MAX_DIM = 4096;
    // Coordinate width and quotient bits produced by the divider
    localparam int NNSA_QW      = $clog2(NNSA_MAX_DIM);
    // Width of a size register
    localparam int NNSA_DIM_W   = 13;
    // Width of a row pitch, of bytes per pixel and of the byte offset
    localparam int NNSA_LINE_W  = 16;
    localparam int NNSA_BPP_W   = 3;
    localparam int NNSA_OFF_W   = 28;
    // Configuration port
    localparam int NNSA_CFG_W   = 16;
    localparam int NNSA_IDX_W   = 3;
    // Register stages from input to output register:
    // product, one per quotient bit, round/clamp, offset products, offset sum
    localparam int NNSA_DEPTH   = NNSA_QW + 4;

    // Register indexes
    typedef enum logic [NNSA_IDX_W-1:0] {
        CFG_SRC_WIDTH       = 3'd0,
        CFG_SRC_HEIGHT      = 3'd1,
        CFG_DST_WIDTH       = 3'd2,
        CFG_DST_HEIGHT      = 3'd3,
        CFG_LINE_BYTES      = 3'd4,
        CFG_BYTES_PER_PIXEL = 3'd5
    } t_cfg_idx;

    // Source and destination size of one axis
    typedef struct packed {
        logic [NNSA_DIM_W-1:0] src_size;
        logic [NNSA_DIM_W-1:0] dst_size;
    } t_axis_cfg;

endpackage

@@ rtl/nnsa_axis.sv @@
// One axis: scale a destination coordinate to the nearest source coordinate.
module nnsa_axis (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  logic [nnsa_pkg::NNSA_QW-1:0] i_coord,
    input  nnsa_pkg::t_axis_cfg          i_cfg,
    output logic [nnsa_pkg::NNSA_QW-1:0] o_coord
);
    import nnsa_pkg::*;

    localparam int PW = NNSA_QW + NNSA_DIM_W;

    // Product stage
    logic [PW-1:0]         r_prod;

    // Divider stages, one quotient bit each
    logic [NNSA_DIM_W-1:0] r_rem [NNSA_QW];
    logic [NNSA_QW-1:0]    r_low [NNSA_QW];
    logic [NNSA_QW-1:0]    r_quo [NNSA_QW];
    logic                  r_ovf [NNSA_QW];

    logic [NNSA_DIM_W-1:0] n_rem [NNSA_QW];
    logic [NNSA_QW-1:0]    n_low [NNSA_QW];
    logic [NNSA_QW-1:0]    n_quo [NNSA_QW];
    logic                  n_ovf [NNSA_QW];

    logic [NNSA_DIM_W-1:0] w_rem_in  [NNSA_QW];
    logic [NNSA_QW-1:0]    w_low_in  [NNSA_QW];
    logic [NNSA_QW-1:0]    w_quo_in  [NNSA_QW];
    logic                  w_ovf_in  [NNSA_QW];
    logic [NNSA_DIM_W:0]   w_part    [NNSA_QW];
    logic                  w_ge      [NNSA_QW];

    // Round and clamp stage
    logic                  w_round;
    logic [NNSA_DIM_W-1:0] w_q_up;
    logic [NNSA_DIM_W-1:0] w_lim_raw;
    logic [NNSA_DIM_W-1:0] w_lim;
    logic [NNSA_QW-1:0]    n_coord;
    logic [NNSA_QW-1:0]    r_coord;

    // Restoring division: the upper product bits start as the partial remainder,
    // the lower bits shift in one per stage. A quotient that would not fit in
    // NNSA_QW bits is flagged as overflow in the first stage.
    always_comb begin
        for (int k = 0; k < NNSA_QW; k++) begin
            if (k == 0) begin
                w_rem_in[k] = r_prod[PW-1:NNSA_QW];
                w_low_in[k] = r_prod[NNSA_QW-1:0];
                w_quo_in[k] = '0;
                w_ovf_in[k] = (r_prod[PW-1:NNSA_QW] >= i_cfg.dst_size);
            end else begin
                w_rem_in[k] = r_rem[k-1];
                w_low_in[k] = r_low[k-1];
                w_quo_in[k] = r_quo[k-1];
                w_ovf_in[k] = r_ovf[k-1];
            end
            w_part[k] = {w_rem_in[k], w_low_in[k][NNSA_QW-1]};
            w_ge[k]   = (w_part[k] >= {1'b0, i_cfg.dst_size});
            n_rem[k]  = w_ge[k] ? NNSA_DIM_W'(w_part[k] - {1'b0, i_cfg.dst_size})
                                : w_part[k][NNSA_DIM_W-1:0];
            n_low[k]  = {w_low_in[k][NNSA_QW-2:0], 1'b0};
            n_quo[k]  = {w_quo_in[k][NNSA_QW-2:0], w_ge[k]};
            n_ovf[k]  = w_ovf_in[k];
        end
    end

    // Round up when twice the remainder exceeds the divisor, then clamp
    // below the source size and below the maximum dimension; a zero size gives 0.
    always_comb begin
        w_round   = ({r_rem[NNSA_QW-1], 1'b0} > {1'b0, i_cfg.dst_size});
        w_q_up    = NNSA_DIM_W'(r_quo[NNSA_QW-1]) + NNSA_DIM_W'(w_round);
        w_lim_raw = i_cfg.src_size - NNSA_DIM_W'(1);
        w_lim     = (w_lim_raw > NNSA_DIM_W'(NNSA_MAX_DIM - 1))
                  ? NNSA_DIM_W'(NNSA_MAX_DIM - 1) : w_lim_raw;
        if (i_cfg.src_size == '0 || i_cfg.dst_size == '0) begin
            n_coord = '0;
        end else if (r_ovf[NNSA_QW-1] || (w_q_up > w_lim)) begin
            n_coord = w_lim[NNSA_QW-1:0];
        end else begin
            n_coord = w_q_up[NNSA_QW-1:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= PW'(i_coord) * PW'(i_cfg.src_size);
            for (int k = 0; k < NNSA_QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= n_ovf[k];
            end
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

@@ rtl/nearest_neighbor_scale_address.sv @@
// Top level of the nearest-neighbor scale address generator.
//
// Usage: present a destination pixel (i_dst_x, i_dst_y) with i_valid; it is
// taken when o_ready is high. Each item yields one result on the output
// channel: the source pixel (o_src_x, o_src_y) that nearest-neighbor scaling
// picks and its byte offset o_byte_offset, taken when o_valid and i_ready.
// Sizes, row pitch and bytes per pixel are set through the write port
// (i_cfg_we, i_cfg_idx, i_cfg_data) while no item is in flight.
// Pipeline: 16 register stages from the accepted item to the output register.
// Throughput: one item per cycle while the skid register is empty.
// The depth is set by the divider, which resolves one quotient bit per stage
// (12 stages per axis), plus product, round/clamp and two offset stages.
// Reset clears all items in flight and loads the default configuration
// (64x64 to 64x64, 256 bytes per row, 4 bytes per pixel).
// When the receiver stalls, the result moves into a one-entry skid register
// and the pipeline holds; o_ready drops only while that register is full.
module nearest_neighbor_scale_address (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [nnsa_pkg::NNSA_IDX_W-1:0]   i_cfg_idx,
    input  logic [nnsa_pkg::NNSA_CFG_W-1:0]   i_cfg_data,
    // Input items
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [nnsa_pkg::NNSA_QW-1:0]      i_dst_x,
    input  logic [nnsa_pkg::NNSA_QW-1:0]      i_dst_y,
    // Result items
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [nnsa_pkg::NNSA_QW-1:0]      o_src_x,
    output logic [nnsa_pkg::NNSA_QW-1:0]      o_src_y,
    output logic [nnsa_pkg::NNSA_OFF_W-1:0]   o_byte_offset
);
    import nnsa_pkg::*;

    localparam int LAST = NNSA_DEPTH - 1;

    // Configuration registers
    logic [NNSA_DIM_W-1:0]  r_src_width;
    logic [NNSA_DIM_W-1:0]  r_src_height;
    logic [NNSA_DIM_W-1:0]  r_dst_width;
    logic [NNSA_DIM_W-1:0]  r_dst_height;
    logic [NNSA_LINE_W-1:0] r_line_bytes;
    logic [NNSA_BPP_W-1:0]  r_bpp;

    t_axis_cfg              w_cfg_x;
    t_axis_cfg              w_cfg_y;

    logic                   w_adv;
    logic [LAST:0]          r_v;

    logic [NNSA_QW-1:0]     w_sx;
    logic [NNSA_QW-1:0]     w_sy;

    // Offset stages
    logic [NNSA_QW-1:0]     r_p_sx;
    logic [NNSA_QW-1:0]     r_p_sy;
    logic [NNSA_OFF_W-1:0]  r_mul_y;
    logic [NNSA_QW+NNSA_BPP_W-1:0] r_mul_x;
    logic [NNSA_QW-1:0]     r_out_sx;
    logic [NNSA_QW-1:0]     r_out_sy;
    logic [NNSA_OFF_W-1:0]  r_out_off;

    // Skid register
    logic                   r_skid_v;
    logic [NNSA_QW-1:0]     r_skid_sx;
    logic [NNSA_QW-1:0]     r_skid_sy;
    logic [NNSA_OFF_W-1:0]  r_skid_off;

    // Write configuration; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= NNSA_DIM_W'(64);
            r_src_height <= NNSA_DIM_W'(64);
            r_dst_width  <= NNSA_DIM_W'(64);
            r_dst_height <= NNSA_DIM_W'(64);
            r_line_bytes <= NNSA_LINE_W'(256);
            r_bpp        <= NNSA_BPP_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:       r_src_width  <= i_cfg_data[NNSA_DIM_W-1:0];
                CFG_SRC_HEIGHT:      r_src_height <= i_cfg_data[NNSA_DIM_W-1:0];
                CFG_DST_WIDTH:       r_dst_width  <= i_cfg_data[NNSA_DIM_W-1:0];
                CFG_DST_HEIGHT:      r_dst_height <= i_cfg_data[NNSA_DIM_W-1:0];
                CFG_LINE_BYTES:      r_line_bytes <= i_cfg_data[NNSA_LINE_W-1:0];
                CFG_BYTES_PER_PIXEL: r_bpp        <= i_cfg_data[NNSA_BPP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg_x = '{src_size: r_src_width,  dst_size: r_dst_width};
    assign w_cfg_y = '{src_size: r_src_height, dst_size: r_dst_height};

    // Pipeline advances unless the skid register holds an item
    assign w_adv   = !r_skid_v;
    assign o_ready = w_adv;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    nnsa_axis u_axis_x (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_coord (i_dst_x),
        .i_cfg   (w_cfg_x),
        .o_coord (w_sx)
    );

    nnsa_axis u_axis_y (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_coord (i_dst_y),
        .i_cfg   (w_cfg_y),
        .o_coord (w_sy)
    );

    // Form the byte offset: products, then the sum wrapped to the offset width
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_sx    <= w_sx;
            r_p_sy    <= w_sy;
            r_mul_y   <= NNSA_OFF_W'(w_sy) * NNSA_OFF_W'(r_line_bytes);
            r_mul_x   <= (NNSA_QW+NNSA_BPP_W)'(w_sx) * (NNSA_QW+NNSA_BPP_W)'(r_bpp);
            r_out_sx  <= r_p_sx;
            r_out_sy  <= r_p_sy;
            r_out_off <= r_mul_y + NNSA_OFF_W'(r_mul_x);
        end
    end

    // Catch the finished item when the receiver stalls; release it on ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_v[LAST] && !i_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_sx  <= r_out_sx;
            r_skid_sy  <= r_out_sy;
            r_skid_off <= r_out_off;
        end
    end

    // Present the oldest item: the skid register first
    assign o_valid       = r_skid_v | r_v[LAST];
    assign o_src_x       = r_skid_v ? r_skid_sx  : r_out_sx;
    assign o_src_y       = r_skid_v ? r_skid_sy  : r_out_sy;
    assign o_byte_offset = r_skid_v ? r_skid_off : r_out_off;

endmodule
